// ----- rtl/biou_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package biou_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // valid bit and overlap flag riding along with each word
    typedef struct packed {
        logic valid;
        logic hit;
    } t_ctl;

endpackage

`default_nettype wire

// ----- rtl/biou_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module biou_front #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
    localparam int CW = COORD_BITS,
    localparam int AW = 2 * COORD_BITS - 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [CW-1:0] i_a_left,
    input  wire logic signed [CW-1:0] i_a_top,
    input  wire logic [CW-2:0]        i_a_width,
    input  wire logic [CW-2:0]        i_a_height,
    input  wire logic signed [CW-1:0] i_b_left,
    input  wire logic signed [CW-1:0] i_b_top,
    input  wire logic [CW-2:0]        i_b_width,
    input  wire logic [CW-2:0]        i_b_height,
    output biou_pkg::t_ctl            o_ctl,
    output logic [AW-1:0]             o_num,
    output logic [AW-1:0]             o_den
);

    // stage 1: origin maxima and far edge minima
    logic signed [CW:0]   n_ax2, n_bx2, n_ay2, n_by2;
    logic                 r_v1;
    logic signed [CW-1:0] r_x1, r_y1;
    logic signed [CW:0]   r_x2, r_y2;
    logic [CW-2:0]        r_aw1, r_ah1, r_bw1, r_bh1;

    assign n_ax2 = $signed({i_a_left[CW-1], i_a_left}) + $signed({2'b00, i_a_width});
    assign n_bx2 = $signed({i_b_left[CW-1], i_b_left}) + $signed({2'b00, i_b_width});
    assign n_ay2 = $signed({i_a_top[CW-1], i_a_top}) + $signed({2'b00, i_a_height});
    assign n_by2 = $signed({i_b_top[CW-1], i_b_top}) + $signed({2'b00, i_b_height});

    // stage 2: intersection extents
    logic signed [CW+1:0] n_dx, n_dy;
    logic                 r_v2, r_ok2;
    logic [CW-2:0]        r_dx, r_dy;
    logic [CW-2:0]        r_aw2, r_ah2, r_bw2, r_bh2;

    assign n_dx = $signed({r_x2[CW], r_x2}) - $signed({{2{r_x1[CW-1]}}, r_x1});
    assign n_dy = $signed({r_y2[CW], r_y2}) - $signed({{2{r_y1[CW-1]}}, r_y1});

    // stage 3: areas
    logic                 r_v3, r_ok3;
    logic [2*CW-3:0]      r_inter, r_area_a, r_area_b;

    // stage 4: union
    logic [AW-1:0]        n_union;
    logic                 r_v4, r_hit4;
    logic [AW-1:0]        r_num, r_den;

    assign n_union = {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1  <= (i_a_left > i_b_left) ? i_a_left : i_b_left;
            r_y1  <= (i_a_top > i_b_top) ? i_a_top : i_b_top;
            r_x2  <= (n_ax2 < n_bx2) ? n_ax2 : n_bx2;
            r_y2  <= (n_ay2 < n_by2) ? n_ay2 : n_by2;
            r_aw1 <= i_a_width;
            r_ah1 <= i_a_height;
            r_bw1 <= i_b_width;
            r_bh1 <= i_b_height;

            r_ok2 <= !n_dx[CW+1] && !n_dy[CW+1];
            r_dx  <= n_dx[CW-2:0];
            r_dy  <= n_dy[CW-2:0];
            r_aw2 <= r_aw1;
            r_ah2 <= r_ah1;
            r_bw2 <= r_bw1;
            r_bh2 <= r_bh1;

            r_ok3    <= r_ok2;
            r_inter  <= r_dx * r_dy;
            r_area_a <= r_aw2 * r_ah2;
            r_area_b <= r_bw2 * r_bh2;

            r_hit4 <= r_ok3 && (n_union != '0);
            r_num  <= {1'b0, r_inter};
            r_den  <= n_union;
        end
    end

    assign o_ctl.valid = r_v4;
    assign o_ctl.hit   = r_hit4;
    assign o_num       = r_num;
    assign o_den       = r_den;

endmodule

`default_nettype wire

// ----- rtl/biou_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module biou_cell #(
    parameter int AW    = 2 * biou_pkg::COORD_BITS_DEF - 1,
    parameter int QW    = biou_pkg::FRAC_BITS_DEF + 1,
    parameter bit FIRST = 1'b0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire biou_pkg::t_ctl i_ctl,
    input  wire logic [AW-1:0]  i_rem,
    input  wire logic [AW-1:0]  i_den,
    input  wire logic [QW-1:0]  i_quo,
    output biou_pkg::t_ctl      o_ctl,
    output logic [AW-1:0]       o_rem,
    output logic [AW-1:0]       o_den,
    output logic [QW-1:0]       o_quo
);

    logic [AW:0]    n_shift;
    logic           n_ge;
    logic [AW:0]    n_diff;
    logic           r_valid, r_hit;
    logic [AW-1:0]  r_rem, r_den;
    logic [QW-1:0]  r_quo;

    // one restoring step: shift, compare, subtract
    assign n_shift = FIRST ? {1'b0, i_rem} : {i_rem, 1'b0};
    assign n_ge    = n_shift >= {1'b0, i_den};
    assign n_diff  = n_shift - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= i_ctl.hit;
            r_rem <= n_ge ? n_diff[AW-1:0] : n_shift[AW-1:0];
            r_den <= i_den;
            r_quo <= {i_quo[QW-2:0], n_ge};
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.hit   = r_hit;
    assign o_rem       = r_rem;
    assign o_den       = r_den;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire

// ----- rtl/box_iou.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake          payload
// input    in         i_valid/o_ready    i_a_*, i_b_* box origins and sizes
// output   out        o_valid/i_ready    o_ratio, o_overlaps
//
// one word per cycle while the chain is not held; four geometry stages,
// then one divider cell per quotient bit
// the whole chain advances together; it holds only while the output
// word is waiting and i_ready is low
// reset clears the valid bits of every stage

module box_iou #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = biou_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_a_left,
    input  wire logic signed [COORD_BITS-1:0] i_a_top,
    input  wire logic [COORD_BITS-2:0]        i_a_width,
    input  wire logic [COORD_BITS-2:0]        i_a_height,
    input  wire logic signed [COORD_BITS-1:0] i_b_left,
    input  wire logic signed [COORD_BITS-1:0] i_b_top,
    input  wire logic [COORD_BITS-2:0]        i_b_width,
    input  wire logic [COORD_BITS-2:0]        i_b_height,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [FRAC_BITS:0]                o_ratio,
    output logic                              o_overlaps
);

    localparam int AW = 2 * COORD_BITS - 1;
    localparam int QW = FRAC_BITS + 1;

    logic           w_en;
    biou_pkg::t_ctl w_ctl [0:QW];
    logic [AW-1:0]  w_rem [0:QW];
    logic [AW-1:0]  w_den [0:QW];
    logic [QW-1:0]  w_quo [0:QW];

    assign w_en    = i_ready || !w_ctl[QW].valid;
    assign o_ready = w_en;

    biou_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_width  (i_a_width),
        .i_a_height (i_a_height),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_width  (i_b_width),
        .i_b_height (i_b_height),
        .o_ctl      (w_ctl[0]),
        .o_num      (w_rem[0]),
        .o_den      (w_den[0])
    );

    assign w_quo[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        biou_cell #(
            .AW    (AW),
            .QW    (QW),
            .FIRST (g == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_den   (w_den[g]),
            .i_quo   (w_quo[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_den[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    assign o_valid    = w_ctl[QW].valid;
    assign o_overlaps = w_ctl[QW].hit;
    assign o_ratio    = w_ctl[QW].hit ? w_quo[QW] : '0;

endmodule

`default_nettype wire

// ----- dv/tb_box_iou.sv -----
`timescale 1ns / 1ps

module tb_box_iou;

    localparam int CB = biou_pkg::COORD_BITS_DEF;
    localparam int FB = biou_pkg::FRAC_BITS_DEF;

    typedef struct {
        logic signed [CB-1:0] a_left;
        logic signed [CB-1:0] a_top;
        logic [CB-2:0]        a_width;
        logic [CB-2:0]        a_height;
        logic signed [CB-1:0] b_left;
        logic signed [CB-1:0] b_top;
        logic [CB-2:0]        b_width;
        logic [CB-2:0]        b_height;
    } t_box_pair;

    typedef struct {
        logic [FB:0] ratio;
        logic        overlaps;
    } t_iou_result;

    class iou_scoreboard;
        t_iou_result expected_iou[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            mismatches++;
        endtask

        function t_iou_result iou_of(t_box_pair p);
            longint al, at, aw, ah, bl, bt, bw, bh;
            longint x1, y1, x2, y2, inter, uni;
            t_iou_result r;
            al = longint'(p.a_left);
            at = longint'(p.a_top);
            aw = longint'(p.a_width);
            ah = longint'(p.a_height);
            bl = longint'(p.b_left);
            bt = longint'(p.b_top);
            bw = longint'(p.b_width);
            bh = longint'(p.b_height);
            x1 = (al > bl) ? al : bl;
            y1 = (at > bt) ? at : bt;
            x2 = (al + aw < bl + bw) ? al + aw : bl + bw;
            y2 = (at + ah < bt + bh) ? at + ah : bt + bh;
            r.ratio    = '0;
            r.overlaps = 1'b0;
            if (x2 >= x1 && y2 >= y1) begin
                inter = (x2 - x1) * (y2 - y1);
                uni   = aw * ah + bw * bh - inter;
                if (uni > 0) begin
                    r.overlaps = 1'b1;
                    r.ratio    = (FB + 1)'((inter <<< FB) / uni);
                end
            end
            return r;
        endfunction

        function void note_pair(t_box_pair p);
            expected_iou.push_back(iou_of(p));
        endfunction

        function int pending();
            return expected_iou.size();
        endfunction

        task check_result(logic [FB:0] ratio, logic overlaps);
            t_iou_result e;
            if (expected_iou.size() == 0) begin
                report_mismatch($sformatf("unexpected word ratio=%0d overlaps=%0b",
                                          ratio, overlaps));
            end else begin
                e = expected_iou.pop_front();
                if (ratio !== e.ratio)
                    report_mismatch($sformatf("ratio got %0d want %0d", ratio, e.ratio));
                if (overlaps !== e.overlaps)
                    report_mismatch($sformatf("overlaps got %0b want %0b",
                                              overlaps, e.overlaps));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic signed [CB-1:0] i_a_left;
    logic signed [CB-1:0] i_a_top;
    logic [CB-2:0]        i_a_width;
    logic [CB-2:0]        i_a_height;
    logic signed [CB-1:0] i_b_left;
    logic signed [CB-1:0] i_b_top;
    logic [CB-2:0]        i_b_width;
    logic [CB-2:0]        i_b_height;
    logic                 o_valid;
    logic                 i_ready;
    logic [FB:0]          o_ratio;
    logic                 o_overlaps;

    iou_scoreboard sb;
    bit            calm;

    box_iou dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_width  (i_a_width),
        .i_a_height (i_a_height),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_width  (i_b_width),
        .i_b_height (i_b_height),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_ratio    (o_ratio),
        .o_overlaps (o_overlaps)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // valid stays high across back-to-back words, lowered only for a gap
    task automatic send_pair(t_box_pair p);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_a_left   <= p.a_left;
        i_a_top    <= p.a_top;
        i_a_width  <= p.a_width;
        i_a_height <= p.a_height;
        i_b_left   <= p.b_left;
        i_b_top    <= p.b_top;
        i_b_width  <= p.b_width;
        i_b_height <= p.b_height;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_pair(p);
    endtask

    task automatic push_pair(int al, int at, int aw, int ah, int bl, int bt, int bw, int bh);
        t_box_pair p;
        p.a_left   = CB'(al);
        p.a_top    = CB'(at);
        p.a_width  = (CB-1)'(aw);
        p.a_height = (CB-1)'(ah);
        p.b_left   = CB'(bl);
        p.b_top    = CB'(bt);
        p.b_width  = (CB-1)'(bw);
        p.b_height = (CB-1)'(bh);
        send_pair(p);
    endtask

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_ratio, o_overlaps);
    end

    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 9);
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int size_caps[4];
        int cap, kind, mask;
        int al, at, aw, ah, bl, bt, bw, bh;
        size_caps[0] = 15;
        size_caps[1] = 255;
        size_caps[2] = 4095;
        size_caps[3] = 32767;
        sb         = new();
        calm       = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_a_left   = '0;
        i_a_top    = '0;
        i_a_width  = '0;
        i_a_height = '0;
        i_b_left   = '0;
        i_b_top    = '0;
        i_b_width  = '0;
        i_b_height = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identical boxes
        push_pair(0, 0, 100, 100, 0, 0, 100, 100);
        push_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        push_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        // separated on one or both axes
        push_pair(0, 0, 10, 10, 20, 0, 10, 10);
        push_pair(0, 0, 10, 10, 0, -30, 10, 10);
        push_pair(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767);
        push_pair(-32768, -32768, 32767, 32767, 0, 0, 32767, 32767);
        // touching edges and corners
        push_pair(0, 0, 10, 10, 10, 0, 10, 10);
        push_pair(0, 0, 10, 10, 0, 10, 10, 10);
        push_pair(0, 0, 10, 10, -10, -10, 10, 10);
        push_pair(-32768, -32768, 32767, 32767, -1, -1, 32767, 32767);
        // empty union
        push_pair(0, 0, 0, 0, 0, 0, 0, 0);
        push_pair(-32768, 32767, 0, 0, -32768, 32767, 0, 0);
        push_pair(5, 5, 0, 0, 100, 100, 0, 0);
        push_pair(3, 3, 0, 7, 3, 3, 7, 0);
        // degenerate box against a real one
        push_pair(5, 5, 0, 0, 0, 0, 10, 10);
        push_pair(5, 0, 0, 10, 0, 0, 10, 10);
        // containment, partial overlap and thin crossings
        push_pair(10, 10, 5, 5, 0, 0, 100, 100);
        push_pair(0, 0, 20, 10, 10, 0, 20, 10);
        push_pair(0, 0, 32767, 1, 0, 0, 1, 32767);
        push_pair(-2, -2, 32767, 32767, -32768, -32768, 32767, 32767);
        push_pair(32767, 32767, 32767, 32767, 32767, 32767, 1, 1);
        push_pair(-500, -300, 700, 900, -200, -800, 1000, 600);

        for (int n = 0; n < 1150; n++) begin
            calm = ((n / 100) % 4) == 3;
            cap  = size_caps[$urandom_range(0, 3)];
            kind = $urandom_range(0, 99);
            al = int'($urandom_range(0, 65535)) - 32768;
            at = int'($urandom_range(0, 65535)) - 32768;
            aw = $urandom_range(0, cap);
            ah = $urandom_range(0, cap);
            bw = $urandom_range(0, cap);
            bh = $urandom_range(0, cap);
            bl = al - bw - 1 + int'($urandom_range(0, aw + bw + 2));
            bt = at - bh - 1 + int'($urandom_range(0, ah + bh + 2));
            if (kind < 15) begin
                bl = al;
                bt = at;
                bw = aw;
                bh = ah;
            end else if (kind < 25) begin
                // shared edge on x, sometimes a shared corner too
                bl = al + aw;
                if ($urandom_range(0, 1))
                    bt = at + ah;
            end else if (kind < 35) begin
                mask = $urandom_range(1, 15);
                if (mask[0]) aw = 0;
                if (mask[1]) ah = 0;
                if (mask[2]) bw = 0;
                if (mask[3]) bh = 0;
            end else if (kind < 60) begin
                bl = int'($urandom_range(0, 65535)) - 32768;
                bt = int'($urandom_range(0, 65535)) - 32768;
                aw = $urandom_range(0, 32767);
                ah = $urandom_range(0, 32767);
                bw = $urandom_range(0, 32767);
                bh = $urandom_range(0, 32767);
            end
            push_pair(al, at, aw, ah, bl, bt, bw, bh);
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (FB + 20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/biou_pkg.sv
rtl/biou_front.sv
rtl/biou_cell.sv
rtl/box_iou.sv
dv/tb_box_iou.sv
